// File: hw/rtl/hrp_pkg.sv
// Shared types and codes for the request header parser.
// No dependencies; used by hrp_core and http_request_header_parser.
package hrp_pkg;

   localparam logic [2:0] PH_METHOD  = 3'd0;
   localparam logic [2:0] PH_PATH    = 3'd1;
   localparam logic [2:0] PH_VERSION = 3'd2;
   localparam logic [2:0] PH_NAME    = 3'd3;
   localparam logic [2:0] PH_VALUE   = 3'd4;
   localparam logic [2:0] PH_BODY    = 3'd5;

   localparam logic [2:0] CL_METHOD  = 3'd0;
   localparam logic [2:0] CL_PATH    = 3'd1;
   localparam logic [2:0] CL_VERSION = 3'd2;
   localparam logic [2:0] CL_NAME    = 3'd3;
   localparam logic [2:0] CL_VALUE   = 3'd4;
   localparam logic [2:0] CL_BODY    = 3'd5;
   localparam logic [2:0] CL_DELIM   = 3'd6;

   // line-start tracking
   localparam logic [1:0] LS_MID      = 2'd0;
   localparam logic [1:0] LS_LINE_LF  = 2'd1;
   localparam logic [1:0] LS_HDR_HEAD = 2'd2;
   localparam logic [1:0] LS_TERM_LF  = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_INCOMPLETE = 2'd1;
   localparam logic [1:0] ST_ERROR      = 2'd2;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_COLON = 8'h3A;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       lf_next;
      logic       done;
   } hrp_step_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic [2:0]  byte_class;
      logic [4:0]  header_index;
      logic        done_res;
      logic [1:0]  status;
      logic [5:0]  header_total;
      logic [15:0] body_length;
   } hrp_result_type;

endpackage

// File: hw/rtl/http_request_header_parser.sv
// Request header parser top level: byte hold stage, parser core, output buffer.
// Depends on hrp_pkg, hrp_core and hrp_skid.
//
// Labels a request byte stream, one byte per beat, one beat per cycle while no final byte waits
// and the output buffer has room. Each result trails its input by one byte, since a CR is judged
// from the byte after it; the first byte of a buffer yields no result on its own. The final byte
// (req_tlast) is kept apart and judged after the held byte by the same labelling unit, and no
// input is taken meanwhile. Parser state returns to reset after each final byte. Results leave
// through a two-entry buffer, so input keeps flowing while a result waits.
module http_request_header_parser import hrp_pkg::*; #(
   parameter int METHOD_LIMIT  = 16,
   parameter int TARGET_LIMIT  = 256,
   parameter int VERSION_LIMIT = 16,
   parameter int HEADER_LIMIT  = 32,
   parameter int NAME_LIMIT    = 64,
   parameter int VALUE_LIMIT   = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [12:8] header_index, [14:13] status,
                                    // [20:15] header_total, [36:21] body_length, [39:37] zero
   output logic [3:0]  rsp_tuser,   // [0] byte_valid, [3:1] byte_class
   output logic        rsp_tlast    // done_res
);

   localparam int BUF_W = 45;

   logic           held_valid_ff;
   logic [7:0]     held_byte_ff;
   logic           tail_valid_ff;
   logic [7:0]     tail_byte_ff;
   logic           acc;
   logic           skid_ready;
   logic           step_valid;
   hrp_step_type   step;
   hrp_result_type result;
   logic [BUF_W-1:0] buf_in;
   logic [BUF_W-1:0] buf_out;

   assign req_tready = !tail_valid_ff && skid_ready;
   assign acc        = req_tvalid && req_tready;
   assign step_valid = tail_valid_ff ? skid_ready : (acc && held_valid_ff);

   assign step.data_byte = tail_valid_ff ? tail_byte_ff : held_byte_ff;
   assign step.lf_next   = !tail_valid_ff && (req_tdata == CH_LF);
   assign step.done      = tail_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         if (tail_valid_ff && skid_ready) tail_valid_ff <= 1'b0;
         if (acc) begin
            held_valid_ff <= !req_tlast;
            if (req_tlast) tail_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         if (req_tlast) tail_byte_ff <= req_tdata;
         else           held_byte_ff <= req_tdata;
      end
   end

   hrp_core #(
      .METHOD_LIMIT  (METHOD_LIMIT),
      .TARGET_LIMIT  (TARGET_LIMIT),
      .VERSION_LIMIT (VERSION_LIMIT),
      .HEADER_LIMIT  (HEADER_LIMIT),
      .NAME_LIMIT    (NAME_LIMIT),
      .VALUE_LIMIT   (VALUE_LIMIT)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid),
      .step       (step),
      .result     (result)
   );

   assign buf_in = {result.byte_class, result.byte_valid, result.done_res, 3'b000,
                    result.body_length, result.header_total, result.status,
                    result.header_index, result.out_byte};

   hrp_skid #(
      .WIDTH (BUF_W)
   ) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step_valid),
      .in_ready  (skid_ready),
      .in_data   (buf_in),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (buf_out)
   );

   assign rsp_tdata = buf_out[39:0];
   assign rsp_tlast = buf_out[40];
   assign rsp_tuser = buf_out[44:41];

`ifndef SYNTHESIS
   a_last_goes_to_tail: assert property (@(posedge clock) disable iff (reset)
      acc && req_tlast |=> tail_valid_ff && !held_valid_ff)
      else $error("final beat not queued for judging");

   a_step_has_room: assert property (@(posedge clock) disable iff (reset)
      step_valid |-> skid_ready)
      else $error("result produced while output buffer full");

   a_held_judged: assert property (@(posedge clock) disable iff (reset)
      acc && held_valid_ff |-> step_valid && !step.done)
      else $error("held byte not judged on accepted beat");

   a_rsp_byte_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[0])
      else $error("result beat without byte_valid");
`endif

endmodule

// File: hw/rtl/hrp_core.sv
// Parser state and the per-byte labelling logic.
// Depends on hrp_pkg.
module hrp_core import hrp_pkg::*; #(
   parameter int METHOD_LIMIT  = 16,
   parameter int TARGET_LIMIT  = 256,
   parameter int VERSION_LIMIT = 16,
   parameter int HEADER_LIMIT  = 32,
   parameter int NAME_LIMIT    = 64,
   parameter int VALUE_LIMIT   = 256
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step_valid,
   input  hrp_step_type   step,
   output hrp_result_type result
);

   localparam int MAX_A = (METHOD_LIMIT > TARGET_LIMIT) ? METHOD_LIMIT : TARGET_LIMIT;
   localparam int MAX_B = (VERSION_LIMIT > NAME_LIMIT) ? VERSION_LIMIT : NAME_LIMIT;
   localparam int MAX_C = (MAX_A > MAX_B) ? MAX_A : MAX_B;
   localparam int FIELD_MAX = (MAX_C > VALUE_LIMIT) ? MAX_C : VALUE_LIMIT;
   localparam int FIELD_W = $clog2(FIELD_MAX + 1);
   localparam int CNT_W = $clog2(HEADER_LIMIT + 1);

   logic [2:0]         phase_ff, phase_in;
   logic [FIELD_W-1:0] field_ff, field_in;
   logic [CNT_W-1:0]   hdr_ff, hdr_in;
   logic               lead_ff, lead_in;
   logic               err_ff, err_in;
   logic               term_ff, term_in;
   logic [1:0]         ls_ff, ls_in;
   logic [15:0]        body_ff, body_in;

   logic [7:0] b;
   logic       crlf;
   logic       idx_en;
   logic       go;
   logic [2:0] cls;
   logic [8:0] hdr_ext;
   logic [8:0] hdr_total_ext;

   assign b    = step.data_byte;
   assign crlf = (b == CH_CR) && step.lf_next;

   always_comb begin
      phase_in = phase_ff;
      field_in = field_ff;
      hdr_in   = hdr_ff;
      lead_in  = lead_ff;
      err_in   = err_ff;
      term_in  = term_ff;
      ls_in    = ls_ff;
      body_in  = body_ff;
      idx_en   = 1'b0;
      go       = 1'b0;
      cls      = CL_DELIM;
      if (phase_ff == PH_BODY) begin
         if (body_ff != 16'hFFFF) body_in = body_ff + 16'd1;
         cls = CL_BODY;
      end else if (ls_ff == LS_LINE_LF) begin
         idx_en = (phase_ff == PH_NAME) || (phase_ff == PH_VALUE);
         if (phase_ff == PH_VERSION) begin
            if (field_ff == '0 || field_ff >= FIELD_W'(VERSION_LIMIT)) err_in = 1'b1;
         end else if (phase_ff == PH_VALUE) begin
            if (field_ff >= FIELD_W'(VALUE_LIMIT)) err_in = 1'b1;
            if (hdr_ff < CNT_W'(HEADER_LIMIT)) hdr_in = hdr_ff + CNT_W'(1);
         end else begin
            err_in = 1'b1;
         end
         phase_in = PH_NAME;
         field_in = '0;
         lead_in  = 1'b0;
         ls_in    = LS_HDR_HEAD;
      end else if (ls_ff == LS_TERM_LF) begin
         phase_in = PH_BODY;
         ls_in    = LS_MID;
      end else begin
         go = 1'b1;
         if (ls_ff == LS_HDR_HEAD) begin
            if (crlf) begin
               ls_in   = LS_TERM_LF;
               term_in = 1'b1;
               go      = 1'b0;
            end else begin
               ls_in = LS_MID;
               if (hdr_ff >= CNT_W'(HEADER_LIMIT)) err_in = 1'b1;
            end
         end
         if (go) begin
            idx_en = (phase_ff == PH_NAME) || (phase_ff == PH_VALUE);
            if (crlf) begin
               ls_in = LS_LINE_LF;
            end else begin
               case (phase_ff)
                  PH_METHOD: begin
                     if (b == CH_SP) begin
                        if (field_ff >= FIELD_W'(METHOD_LIMIT)) err_in = 1'b1;
                        phase_in = PH_PATH;
                        field_in = '0;
                     end else begin
                        cls = CL_METHOD;
                     end
                  end
                  PH_PATH: begin
                     if (b == CH_SP) begin
                        if (field_ff >= FIELD_W'(TARGET_LIMIT)) err_in = 1'b1;
                        phase_in = PH_VERSION;
                        field_in = '0;
                     end else begin
                        cls = CL_PATH;
                     end
                  end
                  PH_VERSION: begin
                     cls = CL_VERSION;
                  end
                  PH_NAME: begin
                     if (b == CH_COLON) begin
                        if (field_ff == '0 || field_ff >= FIELD_W'(NAME_LIMIT)) err_in = 1'b1;
                        phase_in = PH_VALUE;
                        field_in = '0;
                        lead_in  = 1'b1;
                     end else begin
                        cls = CL_NAME;
                     end
                  end
                  default: begin
                     if (!(lead_ff && (b == CH_SP || b == CH_TAB))) begin
                        lead_in = 1'b0;
                        cls     = CL_VALUE;
                     end
                  end
               endcase
               if (cls != CL_DELIM && field_ff != FIELD_W'(FIELD_MAX))
                  field_in = field_ff + FIELD_W'(1);
            end
         end
      end
   end

   assign hdr_ext       = 9'(hdr_ff);
   assign hdr_total_ext = 9'(hdr_in);

   always_comb begin
      result            = '0;
      result.out_byte   = b;
      if (cls == CL_NAME && b inside {[8'h41:8'h5A]}) result.out_byte = b + 8'd32;
      result.byte_valid = 1'b1;
      result.byte_class = cls;
      if (idx_en) result.header_index = (hdr_ext > 9'd31) ? 5'd31 : hdr_ext[4:0];
      result.done_res = step.done;
      if (step.done) begin
         result.status       = !term_in ? ST_INCOMPLETE : (err_in ? ST_ERROR : ST_OK);
         result.header_total = (hdr_total_ext > 9'd63) ? 6'd63 : hdr_total_ext[5:0];
         result.body_length  = body_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step_valid && step.done)) begin
         phase_ff <= PH_METHOD;
         field_ff <= '0;
         hdr_ff   <= '0;
         lead_ff  <= 1'b0;
         err_ff   <= 1'b0;
         term_ff  <= 1'b0;
         ls_ff    <= LS_MID;
         body_ff  <= '0;
      end else if (step_valid) begin
         phase_ff <= phase_in;
         field_ff <= field_in;
         hdr_ff   <= hdr_in;
         lead_ff  <= lead_in;
         err_ff   <= err_in;
         term_ff  <= term_in;
         ls_ff    <= ls_in;
         body_ff  <= body_in;
      end
   end

endmodule

// File: hw/rtl/hrp_skid.sv
// Two-entry output buffer; registered valid, data and ready.
// No dependencies.
module hrp_skid #(
   parameter int WIDTH = 45
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [1:0]       count_ff;
   logic [WIDTH-1:0] head_ff;
   logic [WIDTH-1:0] spare_ff;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (pop && count_ff == 2'd2) begin
         head_ff <= spare_ff;
      end else if (push && (count_ff == 2'd0 || pop)) begin
         head_ff <= in_data;
      end
      if (push && !pop && count_ff == 2'd1) spare_ff <= in_data;
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for http_request_header_parser: random and directed request buffers,
// labels predicted per byte and compared beat by beat. Depends on hrp_pkg and the parser RTL.
module tb_top;
   import hrp_pkg::*;

   localparam int METHOD_LIMIT  = 16;
   localparam int TARGET_LIMIT  = 256;
   localparam int VERSION_LIMIT = 16;
   localparam int HEADER_LIMIT  = 32;
   localparam int NAME_LIMIT    = 64;
   localparam int VALUE_LIMIT   = 256;
   localparam int RANDOM_BYTES  = 1100;
   localparam int STALL_LIMIT   = 200;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } req_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tlast = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [7:0] out_byte, [12:8] header_index, [14:13] status,
                                     // [20:15] header_total, [36:21] body_length
   logic [3:0]  rsp_tuser;           // [0] byte_valid, [3:1] byte_class
   logic        rsp_tlast;           // done_res

   http_request_header_parser #(
      .METHOD_LIMIT(METHOD_LIMIT), .TARGET_LIMIT(TARGET_LIMIT),
      .VERSION_LIMIT(VERSION_LIMIT), .HEADER_LIMIT(HEADER_LIMIT),
      .NAME_LIMIT(NAME_LIMIT), .VALUE_LIMIT(VALUE_LIMIT)
   ) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   req_beat_type   request_bytes[$];
   hrp_result_type expected_labels[$];
   logic [7:0]     frame_buf[$];

   int fail_count;
   int bytes_queued;
   int frames_queued;
   int results_checked;
   int ends_checked;

   // parser state mirror
   logic [2:0]  ps_phase;
   logic [7:0]  ps_held;
   bit          ps_held_ok;
   int unsigned ps_field_len;
   int unsigned ps_headers;
   int unsigned ps_body;
   bit          ps_lead_blank;
   bit          ps_err;
   bit          ps_term;
   logic [1:0]  ps_line;

   function automatic void parser_clear();
      ps_phase      = PH_METHOD;
      ps_held       = 8'h00;
      ps_held_ok    = 1'b0;
      ps_field_len  = 0;
      ps_headers    = 0;
      ps_body       = 0;
      ps_lead_blank = 1'b0;
      ps_err        = 1'b0;
      ps_term       = 1'b0;
      ps_line       = LS_MID;
   endfunction

   function automatic logic [4:0] line_index();
      return (ps_headers > 31) ? 5'd31 : 5'(ps_headers);
   endfunction

   function automatic void grow_field();
      if (ps_field_len < 65535) ps_field_len++;
   endfunction

   function automatic logic [2:0] classify(input logic [7:0] b, input bit lf_next,
                                           output logic [4:0] idx);
      bit crlf;
      crlf = (b == CH_CR) && lf_next;
      idx = 5'd0;
      if (ps_phase == PH_BODY) begin
         if (ps_body < 65535) ps_body++;
         return CL_BODY;
      end
      if (ps_line == LS_LINE_LF) begin
         if (ps_phase == PH_NAME || ps_phase == PH_VALUE) idx = line_index();
         case (ps_phase)
            PH_VERSION: begin
               if (ps_field_len == 0 || ps_field_len >= VERSION_LIMIT) ps_err = 1'b1;
            end
            PH_VALUE: begin
               if (ps_field_len >= VALUE_LIMIT) ps_err = 1'b1;
               if (ps_headers < HEADER_LIMIT) ps_headers++;
            end
            default: ps_err = 1'b1;
         endcase
         ps_phase      = PH_NAME;
         ps_field_len  = 0;
         ps_lead_blank = 1'b0;
         ps_line       = LS_HDR_HEAD;
         return CL_DELIM;
      end
      if (ps_line == LS_TERM_LF) begin
         ps_phase = PH_BODY;
         ps_line  = LS_MID;
         return CL_DELIM;
      end
      if (ps_line == LS_HDR_HEAD) begin
         if (crlf) begin
            ps_line = LS_TERM_LF;
            ps_term = 1'b1;
            return CL_DELIM;
         end
         ps_line = LS_MID;
         if (ps_headers >= HEADER_LIMIT) ps_err = 1'b1;
      end
      if (ps_phase == PH_NAME || ps_phase == PH_VALUE) idx = line_index();
      if (crlf) begin
         ps_line = LS_LINE_LF;
         return CL_DELIM;
      end
      case (ps_phase)
         PH_METHOD: begin
            if (b == CH_SP) begin
               if (ps_field_len >= METHOD_LIMIT) ps_err = 1'b1;
               ps_phase     = PH_PATH;
               ps_field_len = 0;
               return CL_DELIM;
            end
            grow_field();
            return CL_METHOD;
         end
         PH_PATH: begin
            if (b == CH_SP) begin
               if (ps_field_len >= TARGET_LIMIT) ps_err = 1'b1;
               ps_phase     = PH_VERSION;
               ps_field_len = 0;
               return CL_DELIM;
            end
            grow_field();
            return CL_PATH;
         end
         PH_VERSION: begin
            grow_field();
            return CL_VERSION;
         end
         PH_NAME: begin
            if (b == CH_COLON) begin
               if (ps_field_len == 0 || ps_field_len >= NAME_LIMIT) ps_err = 1'b1;
               ps_phase      = PH_VALUE;
               ps_field_len  = 0;
               ps_lead_blank = 1'b1;
               return CL_DELIM;
            end
            grow_field();
            return CL_NAME;
         end
         default: begin
            if (ps_lead_blank && (b == CH_SP || b == CH_TAB)) return CL_DELIM;
            ps_lead_blank = 1'b0;
            grow_field();
            return CL_VALUE;
         end
      endcase
   endfunction

   function automatic hrp_result_type label_byte(logic [7:0] b, bit lf_next, bit done);
      hrp_result_type r;
      logic [4:0]     idx;
      r = '0;
      r.byte_class = classify(b, lf_next, idx);
      r.out_byte   = b;
      if (r.byte_class == CL_NAME && b >= 8'h41 && b <= 8'h5A) r.out_byte = b + 8'd32;
      r.byte_valid   = 1'b1;
      r.header_index = idx;
      r.done_res     = done;
      if (done) begin
         r.status       = !ps_term ? ST_INCOMPLETE : (ps_err ? ST_ERROR : ST_OK);
         r.header_total = (ps_headers > 63) ? 6'd63 : 6'(ps_headers);
         r.body_length  = 16'(ps_body);
      end
      return r;
   endfunction

   task automatic take_byte(logic [7:0] b, logic last);
      if (ps_held_ok) begin
         expected_labels.push_back(label_byte(ps_held, b == CH_LF, 1'b0));
         ps_held_ok = 1'b0;
      end
      if (last) begin
         expected_labels.push_back(label_byte(b, 1'b0, 1'b1));
         parser_clear();
      end else begin
         ps_held    = b;
         ps_held_ok = 1'b1;
      end
   endtask

   task automatic match_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   // driver
   int send_wait;
   bit send_idle = 1'b1;

   always @(posedge clock) begin : drive_proc
      bit           pend;
      req_beat_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = 0;
         parser_clear();
      end else begin
         pend = req_tvalid;
         if (req_tvalid && req_tready) begin
            take_byte(req_tdata, req_tlast);
            pend = 1'b0;
            if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
            send_wait = send_idle ? $urandom_range(0, 5) : 0;
         end
         if (!pend) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (request_bytes.size() > 0) begin
               nxt = request_bytes.pop_front();
               req_tdata <= nxt.data;
               req_tlast <= nxt.last;
               pend = 1'b1;
            end
         end
         req_tvalid <= pend;
      end
   end

   // monitor
   int recv_wait;
   bit recv_idle = 1'b1;

   always @(posedge clock) begin : collect_proc
      bit             rdy;
      hrp_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait = 0;
      end else begin
         rdy = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_labels.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual tdata=%h tuser=%h tlast=%b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = expected_labels.pop_front();
               match_field("out_byte", 32'(want.out_byte), 32'(rsp_tdata[7:0]));
               match_field("byte_valid", 32'(want.byte_valid), 32'(rsp_tuser[0]));
               match_field("byte_class", 32'(want.byte_class), 32'(rsp_tuser[3:1]));
               match_field("header_index", 32'(want.header_index), 32'(rsp_tdata[12:8]));
               match_field("done", 32'(want.done_res), 32'(rsp_tlast));
               match_field("status", 32'(want.status), 32'(rsp_tdata[14:13]));
               match_field("header_total", 32'(want.header_total), 32'(rsp_tdata[20:15]));
               match_field("body_length", 32'(want.body_length), 32'(rsp_tdata[36:21]));
               results_checked++;
               if (want.done_res) ends_checked++;
            end
            rdy = 1'b0;
            if ($urandom_range(0, 39) == 0) recv_idle = !recv_idle;
            recv_wait = recv_idle ? $urandom_range(0, 5) : 0;
         end
         if (!rdy) begin
            if (recv_wait > 0) recv_wait--;
            else rdy = 1'b1;
         end
         rsp_tready <= rdy;
      end
   end

   // watchdog
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d bytes unsent, %0d labels outstanding",
                  $time, STALL_LIMIT, request_bytes.size(), expected_labels.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus helpers
   task automatic put_byte(logic [7:0] c);
      frame_buf.push_back(c);
   endtask

   task automatic put_str(string s);
      for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
   endtask

   task automatic put_eol();
      frame_buf.push_back(CH_CR);
      frame_buf.push_back(CH_LF);
   endtask

   task automatic put_line(string s);
      put_str(s);
      put_eol();
   endtask

   task automatic put_rep(logic [7:0] c, int n);
      repeat (n) frame_buf.push_back(c);
   endtask

   task automatic ship_frame();
      req_beat_type beat;
      for (int i = 0; i < frame_buf.size(); i++) begin
         beat.data = frame_buf[i];
         beat.last = (i == frame_buf.size() - 1);
         request_bytes.push_back(beat);
      end
      bytes_queued += frame_buf.size();
      frames_queued++;
      frame_buf.delete();
   endtask

   function automatic logic [7:0] pick_token_char();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(8'h41, 8'h5A));
         1: return 8'($urandom_range(8'h61, 8'h7A));
         2: return 8'($urandom_range(8'h30, 8'h39));
         default: return 8'h2D;
      endcase
   endfunction

   function automatic logic [7:0] pick_text_char(bit blanks);
      if (blanks && $urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? CH_SP : CH_TAB;
      return 8'($urandom_range(8'h21, 8'h7E));
   endfunction

   function automatic logic [7:0] pick_noise();
      case ($urandom_range(0, 7))
         0: return CH_CR;
         1: return CH_LF;
         2: return CH_SP;
         3: return CH_COLON;
         4: return CH_TAB;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly short fields, now and then just under, at or just over the limit, or well past it
   function automatic int pick_len(int lo, int hi, int limit);
      if ($urandom_range(0, 29) != 0) return $urandom_range(lo, hi);
      if ($urandom_range(0, 3) == 0) return limit + 300;
      return $urandom_range(limit - 1, limit + 1);
   endfunction

   task automatic put_word(int n);
      repeat (n) put_byte(pick_token_char());
   endtask

   task automatic put_text(int n, bit blanks);
      repeat (n) put_byte(pick_text_char(blanks));
   endtask

   task automatic gen_request();
      int hdr_n;
      int cut;
      put_word(pick_len(1, 7, METHOD_LIMIT));
      put_byte(CH_SP);
      put_byte(8'h2F);
      put_text(pick_len(0, 12, TARGET_LIMIT - 1), 1'b0);
      put_byte(CH_SP);
      if ($urandom_range(0, 2) == 0) put_text(pick_len(0, 10, VERSION_LIMIT), 1'b1);
      else put_str("HTTP/1.1");
      put_eol();
      hdr_n = ($urandom_range(0, 14) == 0) ? $urandom_range(HEADER_LIMIT - 1, HEADER_LIMIT + 2)
                                             : $urandom_range(0, 4);
      repeat (hdr_n) begin
         put_word(pick_len(1, 12, NAME_LIMIT));
         put_byte(CH_COLON);
         repeat ($urandom_range(0, 2)) put_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
         put_text(pick_len(0, 14, VALUE_LIMIT), 1'b1);
         put_eol();
      end
      put_eol();
      repeat ($urandom_range(0, 10)) put_byte(pick_noise());
      case ($urandom_range(0, 19))
         0, 1: begin
            cut = $urandom_range(1, frame_buf.size());
            while (frame_buf.size() > cut) void'(frame_buf.pop_back());
         end
         2, 3: begin
            repeat ($urandom_range(1, 3))
               frame_buf[$urandom_range(0, frame_buf.size() - 1)] = pick_noise();
         end
         4: frame_buf.insert($urandom_range(0, frame_buf.size()),
                             $urandom_range(0, 1) ? CH_CR : CH_LF);
         default: ;
      endcase
      ship_frame();
   endtask

   initial begin : stimulus
      int random_start;

      put_line("GET /index.html HTTP/1.1");
      put_line("Host: example");
      put_line("X-Tab:\t \tv a:l");
      put_eol();
      put_str("body");
      ship_frame();

      put_str("A");
      ship_frame();

      put_str("GET / HTTP/1.1");
      put_byte(CH_CR);
      ship_frame();

      // lone CR and LF inside fields
      put_str("G");
      put_byte(CH_CR);
      put_str("E");
      put_byte(CH_LF);
      put_str("T / V");
      put_byte(CH_LF);
      put_byte(CH_CR);
      put_eol();
      put_eol();
      ship_frame();

      put_line("GET");
      put_eol();
      ship_frame();

      put_line("GET / V");
      put_line("NoColon");
      put_line("Ok:1");
      put_eol();
      ship_frame();

      put_line("GET / ");
      put_line(":x");
      put_eol();
      ship_frame();

      for (int n = METHOD_LIMIT - 1; n <= METHOD_LIMIT; n++) begin
         put_rep(8'h4D, n);
         put_line(" / V");
         put_eol();
         ship_frame();
      end

      put_line("GET / V");
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(CH_COLON);
      put_byte(8'hFF);
      put_eol();
      put_eol();
      put_byte(8'h00);
      put_byte(8'hFF);
      ship_frame();

      put_line("G");
      ship_frame();

      put_line("GET / V");
      put_line("AZaz@[:v");
      put_eol();
      ship_frame();

      put_eol();
      put_eol();
      ship_frame();

      put_line("GET / V");
      repeat (HEADER_LIMIT + 2) put_line("H:v");
      put_eol();
      ship_frame();

      random_start = bytes_queued;
      while (bytes_queued < random_start + RANDOM_BYTES) begin
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 24)) put_byte(pick_noise());
            ship_frame();
         end else begin
            gen_request();
         end
      end

      do @(negedge clock);
      while (request_bytes.size() > 0 || req_tvalid || expected_labels.size() > 0);
      repeat (20) @(negedge clock);

      $display("Sent %0d request buffers (%0d bytes), directed cases plus random requests.",
               frames_queued, bytes_queued);
      $display("Checked %0d labeled bytes, %0d buffer ends, %0d mismatches.",
               results_checked, ends_checked, fail_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
